FILE: rtl/homogeneous_line_clipper_defines.svh
// Assertion macros for the homogeneous line clipper.
// Used by homogeneous_line_clipper.sv; needs a clock named i_clk and reset i_rst_n.
`ifndef HOMOGENEOUS_LINE_CLIPPER_DEFINES_SVH
`define HOMOGENEOUS_LINE_CLIPPER_DEFINES_SVH

// same-cycle implication
`define HLC_AST_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define HLC_AST_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/hlc_pkg.sv
// Shared types and constants for the homogeneous line clipper.
// No dependencies.
package hlc_pkg;

    localparam int UW  = 17;   // u: 16 fraction bits plus the integer bit for 1.0
    localparam int NPL = 6;    // clip planes

    localparam logic [UW-1:0] U_ZERO = 17'h00000;
    localparam logic [UW-1:0] U_ONE  = 17'h10000;

    // which end of the interval a plane narrows
    typedef enum logic [1:0] {
        K_NONE = 2'd0,
        K_HI   = 2'd1,   // B outside: limits u2
        K_LO   = 2'd2    // A outside: limits u1
    } t_kind;

    typedef struct packed {
        logic              valid;
        logic [NPL-1:0]    ca;
        logic [NPL-1:0]    cb;
        t_kind [NPL-1:0]   kind;
        logic [NPL-1:0]    one;    // ratio saturates to 1.0
        logic [NPL-1:0]    zero;   // zero denominator
    } t_ctl;

endpackage

FILE: rtl/hlc_prep.sv
// Front stages: capture, boundary values, plane selection, divider setup.
// Depends on hlc_pkg.
module hlc_prep
    import hlc_pkg::*;
#(
    parameter int POS_WIDTH = 32,
    localparam int PAYW = 8*POS_WIDTH + 192,
    localparam int BW   = POS_WIDTH + 1,
    localparam int DW   = POS_WIDTH + 2,
    localparam int RW   = POS_WIDTH + 3
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  logic [PAYW-1:0]           i_pay,
    output t_ctl                      o_ctl,
    output logic [PAYW-1:0]           o_pay,
    output logic [NPL-1:0][RW-1:0]    o_rem,
    output logic [NPL-1:0][DW-1:0]    o_den
);

    logic                           r_va, r_vb, r_vc;
    logic [PAYW-1:0]                r_pay_a, r_pay_b, r_pay_c;
    logic [1:0][NPL-1:0][BW-1:0]    r_bc, n_bc;
    logic [NPL-1:0]                 r_ca, r_cb, n_ca, n_cb;
    t_kind [NPL-1:0]                r_kind, n_kind;
    logic [NPL-1:0][BW-1:0]         r_na, r_nb, n_na, n_nb;

    // boundary values w-x, w+x, w-y, w+y, w-z, w+z
    always_comb begin
        logic signed [BW-1:0] w;
        logic signed [BW-1:0] x;
        for (int v = 0; v < 2; v++) begin
            w = BW'($signed(r_pay_a[(4*v+3)*POS_WIDTH +: POS_WIDTH]));
            for (int c = 0; c < 3; c++) begin
                x = BW'($signed(r_pay_a[(4*v+c)*POS_WIDTH +: POS_WIDTH]));
                n_bc[v][2*c]   = w - x;
                n_bc[v][2*c+1] = w + x;
            end
        end
    end

    // outcodes and numerator magnitudes
    always_comb begin
        logic [BW-1:0] ba;
        logic [BW-1:0] bb;
        for (int p = 0; p < NPL; p++) begin
            ba = r_bc[0][p];
            bb = r_bc[1][p];
            n_ca[NPL-1-p] = ba[BW-1];
            n_cb[NPL-1-p] = bb[BW-1];
            if (bb[BW-1]) begin
                n_kind[p] = K_HI;
                n_na[p]   = ba;
                n_nb[p]   = -bb;
            end else if (ba[BW-1]) begin
                n_kind[p] = K_LO;
                n_na[p]   = -ba;
                n_nb[p]   = bb;
            end else begin
                n_kind[p] = K_NONE;
                n_na[p]   = '0;
                n_nb[p]   = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va  <= 1'b0;
            r_vb  <= 1'b0;
            r_vc  <= 1'b0;
            o_ctl <= '0;
        end else if (i_en) begin
            r_va  <= i_valid;
            r_vb  <= r_va;
            r_vc  <= r_vb;
            o_ctl.valid <= r_vc;
            o_ctl.ca    <= r_ca;
            o_ctl.cb    <= r_cb;
            o_ctl.kind  <= r_kind;
            for (int p = 0; p < NPL; p++) begin
                o_ctl.one[p]  <= (r_nb[p] == '0) && (r_na[p] != '0);
                o_ctl.zero[p] <= (r_nb[p] == '0) && (r_na[p] == '0);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pay_a <= i_pay;
            r_pay_b <= r_pay_a;
            r_bc    <= n_bc;
            r_pay_c <= r_pay_b;
            r_ca    <= n_ca;
            r_cb    <= n_cb;
            r_kind  <= n_kind;
            r_na    <= n_na;
            r_nb    <= n_nb;
            o_pay   <= r_pay_c;
            for (int p = 0; p < NPL; p++) begin
                o_den[p] <= DW'(r_na[p]) + DW'(r_nb[p]);
                o_rem[p] <= RW'(r_na[p]);
            end
        end
    end

endmodule

FILE: rtl/hlc_div_cell.sv
// One cell of the divider chain: one restoring quotient bit for all six planes.
// Depends on hlc_pkg.
module hlc_div_cell
    import hlc_pkg::*;
#(
    parameter int POS_WIDTH = 32,
    localparam int PAYW = 8*POS_WIDTH + 192,
    localparam int DW   = POS_WIDTH + 2,
    localparam int RW   = POS_WIDTH + 3
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  t_ctl                      i_ctl,
    input  logic [PAYW-1:0]           i_pay,
    input  logic [NPL-1:0][RW-1:0]    i_rem,
    input  logic [NPL-1:0][DW-1:0]    i_den,
    input  logic [NPL-1:0][UW-1:0]    i_q,
    output t_ctl                      o_ctl,
    output logic [PAYW-1:0]           o_pay,
    output logic [NPL-1:0][RW-1:0]    o_rem,
    output logic [NPL-1:0][DW-1:0]    o_den,
    output logic [NPL-1:0][UW-1:0]    o_q
);

    logic [NPL-1:0][RW-1:0] n_rem;
    logic [NPL-1:0][UW-1:0] n_q;

    always_comb begin
        logic [RW-1:0] sub;
        logic          qb;
        for (int p = 0; p < NPL; p++) begin
            if (i_rem[p] >= RW'(i_den[p])) begin
                sub = i_rem[p] - RW'(i_den[p]);
                qb  = 1'b1;
            end else begin
                sub = i_rem[p];
                qb  = 1'b0;
            end
            n_rem[p] = {sub[RW-2:0], 1'b0};
            n_q[p]   = {i_q[p][UW-2:0], qb};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_ctl <= '0;
        end else if (i_en) begin
            o_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_pay <= i_pay;
            o_rem <= n_rem;
            o_den <= i_den;
            o_q   <= n_q;
        end
    end

endmodule

FILE: rtl/hlc_lerp.sv
// One attribute lane of the interpolator: a + round(u*(b-a)), three stages.
// Depends on hlc_pkg.
module hlc_lerp
    import hlc_pkg::*;
#(
    parameter int W = 32,
    localparam int MW  = (W + 1 < UW) ? UW : W + 1,
    localparam int HW  = MW - 16,
    localparam int PHW = HW + UW,
    localparam int PLW = 16 + UW
) (
    input  logic            i_clk,
    input  logic            i_load,
    input  logic            i_en,
    input  logic [W-1:0]    i_a,
    input  logic [W-1:0]    i_b,
    input  logic [UW-1:0]   i_u,
    input  logic            i_clr,
    output logic [W-1:0]    o_val
);

    logic [W-1:0]   r_a, r_pa, r_qa;
    logic [W:0]     r_m, n_d, n_m;
    logic           r_neg, r_pneg, r_qneg, r_pclr, r_qclr;
    logic [MW-1:0]  mx;
    logic [PHW-1:0] r_ph;
    logic [PLW-1:0] r_pl;
    logic [W:0]     r_q;
    logic [W:0]     n_o;

    assign n_d = {i_b[W-1], i_b} - {i_a[W-1], i_a};
    assign n_m = n_d[W] ? -n_d : n_d;
    assign mx  = MW'(r_m);
    assign n_o = r_qneg ? ({r_qa[W-1], r_qa} - r_q) : ({r_qa[W-1], r_qa} + r_q);

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_a   <= i_a;
            r_m   <= n_m;
            r_neg <= n_d[W];
        end
        if (i_en) begin
            // products
            r_ph   <= PHW'(mx[MW-1:16] * i_u);
            r_pl   <= PLW'(mx[15:0] * i_u);
            r_pa   <= r_a;
            r_pneg <= r_neg;
            r_pclr <= i_clr;
            // rounded magnitude, halves up
            r_q    <= (W+1)'(r_ph + PHW'((r_pl + PLW'(32768)) >> 16));
            r_qa   <= r_pa;
            r_qneg <= r_pneg;
            r_qclr <= r_pclr;
            // result
            o_val  <= r_qclr ? '0 : n_o[W-1:0];
        end
    end

endmodule

FILE: rtl/homogeneous_line_clipper.sv
// Top level of the homogeneous (clip-space) Liang-Barsky line clipper.
// Depends on hlc_pkg, hlc_prep, hlc_div_cell, hlc_lerp and the defines header.
//
//  channel   dir  handshake              payload
//  s (seg)   in   i_s_tvalid/o_s_tready  i_s_tdata: two vertices
//  m (vtx)   out  o_m_tvalid/i_m_tready  o_m_tdata: vertex, tuser: accepted, tlast
//
// Each accepted segment yields two output words through the shared interpolator
// lanes, a rejected one a single word; a new segment loads as the last word goes.
// Pipeline: 4 front stages, 17 divider cells, round, issue and 3 lane stages.
// Reset (i_rst_n low, synchronous) clears all valid bits; data is not reset.
// An output stall freezes the lanes, a busy issue stage and a loaded chain behind.
`include "homogeneous_line_clipper_defines.svh"

module homogeneous_line_clipper
    import hlc_pkg::*;
#(
    parameter int POS_WIDTH = 32,
    localparam int PAYW = 8*POS_WIDTH + 192,
    localparam int DW   = POS_WIDTH + 2,
    localparam int RW   = POS_WIDTH + 3,
    localparam int ODR  = 4*POS_WIDTH + 96,
    localparam int ODW  = ((ODR + 7) / 8) * 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    output logic            o_s_tready,
    // ax, ay, az, aw, bx, by, bz, bw, acolor, bcolor, atex, btex (low to high)
    input  logic [PAYW-1:0] i_s_tdata,
    output logic            o_m_tvalid,
    input  logic            i_m_tready,
    // ox, oy, oz, ow, ocolor, otex (low to high), zero padded
    output logic [ODW-1:0]  o_m_tdata,
    output logic            o_m_tlast,
    // accepted
    output logic            o_m_tuser
);

    // divider chain
    t_ctl                    c_ctl [UW+1];
    logic [PAYW-1:0]         c_pay [UW+1];
    logic [NPL-1:0][RW-1:0]  c_rem [UW+1];
    logic [NPL-1:0][DW-1:0]  c_den [UW+1];
    logic [NPL-1:0][UW-1:0]  c_q   [UW+1];

    logic f_en;      // front advance
    logic en2;       // lane advance
    logic take;      // issue stage loads
    logic x_done;

    assign c_q[0] = '0;

    hlc_prep #(.POS_WIDTH(POS_WIDTH)) u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (f_en),
        .i_valid (i_s_tvalid),
        .i_pay   (i_s_tdata),
        .o_ctl   (c_ctl[0]),
        .o_pay   (c_pay[0]),
        .o_rem   (c_rem[0]),
        .o_den   (c_den[0])
    );

    for (genvar k = 0; k < UW; k++) begin : g_cell
        hlc_div_cell #(.POS_WIDTH(POS_WIDTH)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (f_en),
            .i_ctl   (c_ctl[k]),
            .i_pay   (c_pay[k]),
            .i_rem   (c_rem[k]),
            .i_den   (c_den[k]),
            .i_q     (c_q[k]),
            .o_ctl   (c_ctl[k+1]),
            .o_pay   (c_pay[k+1]),
            .o_rem   (c_rem[k+1]),
            .o_den   (c_den[k+1]),
            .o_q     (c_q[k+1])
        );
    end

    // round stage: final remainder test, saturation and zero cases
    t_ctl                   r_r_ctl;
    logic [PAYW-1:0]        r_r_pay;
    logic [NPL-1:0][UW-1:0] r_r_u, n_r_u;

    always_comb begin
        for (int p = 0; p < NPL; p++) begin
            if (c_ctl[UW].one[p]) begin
                n_r_u[p] = U_ONE;
            end else if (c_ctl[UW].zero[p]) begin
                n_r_u[p] = U_ZERO;
            end else if (c_rem[UW][p] >= RW'(c_den[UW][p])) begin
                n_r_u[p] = c_q[UW][p] + UW'(1);
            end else begin
                n_r_u[p] = c_q[UW][p];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r_ctl <= '0;
        end else if (f_en) begin
            r_r_ctl <= c_ctl[UW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (f_en) begin
            r_r_pay <= c_pay[UW];
            r_r_u   <= n_r_u;
        end
    end

    // interval narrowing, planes in order; early reject as soon as it empties
    logic [UW-1:0] n_u1, n_u2;
    logic          n_rej;

    always_comb begin
        n_u1  = U_ZERO;
        n_u2  = U_ONE;
        n_rej = |(r_r_ctl.ca & r_r_ctl.cb);
        for (int p = 0; p < NPL; p++) begin
            if (!n_rej) begin
                case (r_r_ctl.kind[p])
                    K_HI: begin
                        if (r_r_u[p] < n_u1) n_rej = 1'b1;
                        else if (r_r_u[p] < n_u2) n_u2 = r_r_u[p];
                    end
                    K_LO: begin
                        if (r_r_u[p] > n_u2) n_rej = 1'b1;
                        else if (r_r_u[p] > n_u1) n_u1 = r_r_u[p];
                    end
                    default: ;
                endcase
            end
        end
    end

    // issue stage: holds one segment, sends its A then B word, or one if rejected
    logic          r_x_v, r_x_rej, r_x_ph;
    logic [UW-1:0] r_x_u1, r_x_u2;
    logic          r_pv, r_p_acc, r_p_last;
    logic          r_qv, r_q_acc, r_q_last;
    logic          r_ov, r_o_acc, r_o_last;

    assign en2        = !r_ov || i_m_tready;
    assign x_done     = en2 && r_x_v && (r_x_rej || r_x_ph);
    assign take       = !r_x_v || x_done;
    assign f_en       = !r_r_ctl.valid || take;
    assign o_s_tready = f_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_v  <= 1'b0;
            r_x_ph <= 1'b0;
        end else if (take) begin
            r_x_v  <= r_r_ctl.valid;
            r_x_ph <= 1'b0;
        end else if (en2) begin
            r_x_ph <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_x_rej <= n_rej;
            r_x_u1  <= n_u1;
            r_x_u2  <= n_u2;
        end
    end

    // word tags follow the lane stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
            r_qv <= 1'b0;
            r_ov <= 1'b0;
        end else if (en2) begin
            r_pv <= r_x_v;
            r_qv <= r_pv;
            r_ov <= r_qv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_p_acc  <= !r_x_rej;
            r_p_last <= r_x_rej || r_x_ph;
            r_q_acc  <= r_p_acc;
            r_q_last <= r_p_last;
            r_o_acc  <= r_q_acc;
            r_o_last <= r_q_last;
        end
    end

    // interpolator lanes
    logic [UW-1:0]                 issue_u;
    logic [3:0][POS_WIDTH-1:0]     l_pos;
    logic [3:0][8:0]               l_col;
    logic [3:0][15:0]              l_tex;

    assign issue_u = r_x_ph ? r_x_u2 : r_x_u1;

    for (genvar c = 0; c < 4; c++) begin : g_lane
        hlc_lerp #(.W(POS_WIDTH)) u_pos (
            .i_clk  (i_clk),
            .i_load (take),
            .i_en   (en2),
            .i_a    (r_r_pay[c*POS_WIDTH +: POS_WIDTH]),
            .i_b    (r_r_pay[(4+c)*POS_WIDTH +: POS_WIDTH]),
            .i_u    (issue_u),
            .i_clr  (r_x_rej),
            .o_val  (l_pos[c])
        );
        hlc_lerp #(.W(9)) u_col (
            .i_clk  (i_clk),
            .i_load (take),
            .i_en   (en2),
            .i_a    ({1'b0, r_r_pay[8*POS_WIDTH + 24 - 8*c +: 8]}),
            .i_b    ({1'b0, r_r_pay[8*POS_WIDTH + 56 - 8*c +: 8]}),
            .i_u    (issue_u),
            .i_clr  (r_x_rej),
            .o_val  (l_col[c])
        );
        hlc_lerp #(.W(16)) u_tex (
            .i_clk  (i_clk),
            .i_load (take),
            .i_en   (en2),
            .i_a    (r_r_pay[8*POS_WIDTH + 112 - 16*c +: 16]),
            .i_b    (r_r_pay[8*POS_WIDTH + 176 - 16*c +: 16]),
            .i_u    (issue_u),
            .i_clr  (r_x_rej),
            .o_val  (l_tex[c])
        );
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tuser  = r_o_acc;
    assign o_m_tlast  = r_o_last;
    assign o_m_tdata  = ODW'({l_tex[0], l_tex[1], l_tex[2], l_tex[3],
                              l_col[0][7:0], l_col[1][7:0], l_col[2][7:0], l_col[3][7:0],
                              l_pos});

    `HLC_AST_IMP(a_rej_last, o_m_tvalid && !o_m_tuser, o_m_tlast, "reject word without last")
    `HLC_AST_NXT(a_front_hold, !f_en, $stable(r_r_u) && $stable(r_r_ctl), "chain moved in stall")
    `HLC_AST_IMP(a_ph_acc, r_x_v && r_x_ph, !r_x_rej, "second word on a rejected segment")
    `HLC_AST_NXT(a_b_follows, en2 && r_x_v && !r_x_rej && !r_x_ph, r_x_v && r_x_ph,
                 "B word not pending after A word")

endmodule

FILE: tb/sv/homogeneous_line_clipper_chk.sv
// Checker for the homogeneous line clipper: watches both stream channels,
// predicts the clipped vertex words per segment and compares. Needs hlc_pkg.
`timescale 1ns / 100ps

module homogeneous_line_clipper_chk
    import hlc_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    input  logic         i_s_tready,
    input  logic [447:0] i_s_tdata,
    input  logic         i_m_tvalid,
    input  logic         i_m_tready,
    input  logic [223:0] i_m_tdata,
    input  logic         i_m_tlast,
    input  logic         i_m_tuser,
    output int           o_errors,
    output int           o_pending,
    output int           o_rejects,
    output int           o_vertices
);

    typedef struct packed {
        logic         acc;
        logic         last;
        logic [223:0] data;   // ox, oy, oz, ow, ocolor, otex from the lsb up
    } t_vtx_word;

    t_vtx_word clip_q[$];

    assign o_pending = clip_q.size();

    initial begin
        o_errors   = 0;
        o_rejects  = 0;
        o_vertices = 0;
    end

    task automatic report(input string what, input logic [63:0] exp_v, input logic [63:0] got_v);
        $display("%0t mismatch %s: expected %h got %h", $realtime, what, exp_v, got_v);
        o_errors++;
    endtask

    // round(num/den) in 16-bit fraction, halves up, saturating at 1.0
    function automatic longint ratio_u(input longint num, input longint den);
        longint rem, q;
        rem = num;
        q   = 0;
        if (den == 0) return longint'(U_ZERO);
        if (num >= den) return longint'(U_ONE);
        for (int i = 0; i < 17; i++) begin
            q = q << 1;
            if (rem >= den) begin
                rem -= den;
                q |= 1;
            end
            rem = rem << 1;
        end
        if (rem >= den) q += 1;
        return q;
    endfunction

    // a + u*(b-a), product rounded to nearest, halves away from zero
    function automatic longint lerp_u(input longint a, input longint b, input longint u);
        longint d, m, q;
        d = b - a;
        m = (d < 0) ? -d : d;
        q = (m >>> 16) * u + (((m & 64'hFFFF) * u + 32768) >>> 16);
        return (d < 0) ? a - q : a + q;
    endfunction

    function automatic logic [223:0] pack_vtx(input longint v[12]);
        logic [223:0] r;
        r = '0;
        for (int i = 0; i < 4; i++) begin
            r[32*i +: 32]           = v[i][31:0];
            r[128 + 24 - 8*i +: 8]  = v[4+i][7:0];
            r[160 + 48 - 16*i +: 16] = v[8+i][15:0];
        end
        return r;
    endfunction

    task automatic predict_segment(input logic [447:0] d);
        longint va[12], vb[12], oa[12], ob[12];
        longint bca[6], bcb[6];
        logic [5:0] ca, cb;
        longint u1, u2, r;
        logic rej;
        t_vtx_word w;
        for (int i = 0; i < 4; i++) begin
            va[i]   = longint'($signed(d[32*i +: 32]));
            vb[i]   = longint'($signed(d[128 + 32*i +: 32]));
            va[4+i] = longint'(d[256 + 24 - 8*i +: 8]);
            vb[4+i] = longint'(d[288 + 24 - 8*i +: 8]);
            va[8+i] = longint'($signed(d[320 + 48 - 16*i +: 16]));
            vb[8+i] = longint'($signed(d[384 + 48 - 16*i +: 16]));
        end
        for (int k = 0; k < 3; k++) begin
            bca[2*k]   = va[3] - va[k];
            bca[2*k+1] = va[3] + va[k];
            bcb[2*k]   = vb[3] - vb[k];
            bcb[2*k+1] = vb[3] + vb[k];
        end
        for (int k = 0; k < 6; k++) begin
            ca[5-k] = bca[k] < 0;
            cb[5-k] = bcb[k] < 0;
        end
        u1  = longint'(U_ZERO);
        u2  = longint'(U_ONE);
        rej = (ca & cb) != 0;
        if (!rej && (ca | cb) != 0) begin
            for (int k = 0; k < 6 && !rej; k++) begin
                if (bcb[k] < 0) begin
                    r = ratio_u(bca[k], bca[k] - bcb[k]);
                    if (r < u1) rej = 1'b1;
                    else if (r < u2) u2 = r;
                end else if (bca[k] < 0) begin
                    r = ratio_u(-bca[k], bcb[k] - bca[k]);
                    if (r > u2) rej = 1'b1;
                    else if (r > u1) u1 = r;
                end
            end
        end
        if (rej) begin
            w = '{acc: 1'b0, last: 1'b1, data: '0};
            clip_q.push_back(w);
        end else begin
            for (int i = 0; i < 12; i++) begin
                oa[i] = (ca != 0) ? lerp_u(va[i], vb[i], u1) : va[i];
                ob[i] = (cb != 0) ? lerp_u(va[i], vb[i], u2) : vb[i];
            end
            w = '{acc: 1'b1, last: 1'b0, data: pack_vtx(oa)};
            clip_q.push_back(w);
            w = '{acc: 1'b1, last: 1'b1, data: pack_vtx(ob)};
            clip_q.push_back(w);
        end
    endtask

    task automatic check_word();
        t_vtx_word e;
        string names[6];
        int lo[6], wd[6];
        logic [63:0] ev, gv;
        names = '{"ox", "oy", "oz", "ow", "ocolor", "otex"};
        lo    = '{0, 32, 64, 96, 128, 160};
        wd    = '{32, 32, 32, 32, 32, 64};
        if (i_m_tuser) o_vertices++;
        else o_rejects++;
        if (clip_q.size() == 0) begin
            report("unexpected word", 64'd0, {62'd0, i_m_tuser, i_m_tlast});
            return;
        end
        e = clip_q.pop_front();
        if (i_m_tuser !== e.acc) report("accepted", 64'(e.acc), 64'(i_m_tuser));
        if (i_m_tlast !== e.last) report("last", 64'(e.last), 64'(i_m_tlast));
        for (int f = 0; f < 6; f++) begin
            ev = 64'(e.data >> lo[f]);
            gv = 64'(i_m_tdata >> lo[f]);
            if (wd[f] == 32) begin
                ev[63:32] = '0;
                gv[63:32] = '0;
            end
            if (gv !== ev) report(names[f], ev, gv);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && i_s_tready) predict_segment(i_s_tdata);
            if (i_m_tvalid && i_m_tready) check_word();
        end
    end

endmodule

FILE: tb/sv/homogeneous_line_clipper_tb.sv
// Testbench top for the homogeneous line clipper: clock, reset, segment
// stimulus with bursty sender and stalling receiver, verdict. Needs the checker.
`timescale 1ns / 100ps

module homogeneous_line_clipper_tb;
    import hlc_pkg::*;

    localparam int     N_RANDOM = 1500;
    localparam longint ONE      = 65536;      // 1.0 in Q16.16
    localparam int     LIMIT    = 400000;     // cycles

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_tvalid;
    logic         o_s_tready;
    logic [447:0] i_s_tdata;    // ax..bw, acolor, bcolor, atex, btex from the lsb up
    logic         o_m_tvalid;
    logic         i_m_tready;
    logic [223:0] o_m_tdata;    // ox, oy, oz, ow, ocolor, otex from the lsb up
    logic         o_m_tlast;
    logic         o_m_tuser;    // accepted

    int errors, pending, rejects, vertices;
    int cycles;
    int sent;
    int burst_left;

    homogeneous_line_clipper u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

    homogeneous_line_clipper_chk u_chk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_m_tdata  (o_m_tdata),
        .i_m_tlast  (o_m_tlast),
        .i_m_tuser  (o_m_tuser),
        .o_errors   (errors),
        .o_pending  (pending),
        .o_rejects  (rejects),
        .o_vertices (vertices)
    );

    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // watchdog
    initial cycles = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("timeout after %0d cycles, %0d words still expected", cycles, pending);
            $display("FAILURE");
            $finish;
        end
    end

    // receiver: stall mode is redrawn at random - always ready, coin flip,
    // or mostly stalled, so backpressure hits every pipeline phase
    int stall_mode;
    initial stall_mode = 0;
    always @(posedge i_clk) begin
        if (cycles % 64 == 0) stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0: i_m_tready <= 1'b1;
            1: i_m_tready <= $urandom_range(0, 1);
            default: i_m_tready <= ($urandom_range(0, 4) == 0);
        endcase
    end

    // positions are Q16.16; colors and texture words go in raw
    function automatic logic [447:0] seg(input longint p[8], input logic [31:0] ac,
                                         input logic [31:0] bc, input logic [63:0] at,
                                         input logic [63:0] bt);
        logic [447:0] d;
        for (int i = 0; i < 8; i++) d[32*i +: 32] = p[i][31:0];
        d[256 +: 32] = ac;
        d[288 +: 32] = bc;
        d[320 +: 64] = at;
        d[384 +: 64] = bt;
        return d;
    endfunction

    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    // one word on the segment channel; gaps come between random bursts
    task automatic send_segment(input logic [447:0] d);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= d;
        do @(posedge i_clk); while (!o_s_tready);
        sent++;
    endtask

    // straight segment from A to B with random attributes
    task automatic send_line(input longint a[4], input longint b[4]);
        longint p[8];
        for (int i = 0; i < 4; i++) begin
            p[i]   = a[i];
            p[4+i] = b[i];
        end
        send_segment(seg(p, $urandom, $urandom, rnd64(), rnd64()));
    endtask

    task automatic directed_segments();
        longint a[4], b[4], p[8];
        // both endpoints inside
        a = '{0, 0, 0, ONE};
        b = '{ONE/2, -ONE/2, ONE/4, ONE};
        send_line(a, b);
        for (int k = 0; k < 6; k++) begin
            // both beyond the same plane: trivial reject
            a = '{0, 0, 0, ONE};
            b = '{0, 0, 0, ONE};
            a[k/2] = (k % 2 == 0) ? 2*ONE : -2*ONE;
            b[k/2] = (k % 2 == 0) ? 3*ONE : -3*ONE;
            send_line(a, b);
            // B out of this plane only, then A only
            a = '{0, 0, 0, ONE};
            b = '{0, 0, 0, ONE};
            b[k/2] = (k % 2 == 0) ? 3*ONE : -3*ONE;
            send_line(a, b);
            send_line(b, a);
        end
        // both outside, crossing the whole volume
        a = '{-2*ONE, ONE/3, 0, ONE};
        b = '{2*ONE, -ONE/3, ONE/7, ONE};
        send_line(a, b);
        // misses the corner: interval empties
        a = '{-3*ONE, 0, 0, ONE};
        b = '{0, 3*ONE, 0, ONE};
        send_line(a, b);
        // lying on the boundary: zero boundary values count as inside
        a = '{ONE, 0, 0, ONE};
        b = '{ONE, ONE, -ONE, ONE};
        send_line(a, b);
        // negative w on both ends
        a = '{0, 0, 0, -ONE};
        b = '{ONE, 0, 0, -2*ONE};
        send_line(a, b);
        // field extremes
        for (int i = 0; i < 8; i++) p[i] = 32'h7FFFFFFF;
        send_segment(seg(p, '1, '0, '1, '0));
        for (int i = 0; i < 8; i++) p[i] = -64'sd2147483648;
        send_segment(seg(p, '0, '1, '0, '1));
        p = '{-64'sd2147483648, 0, 0, 64'sd2147483647,
              64'sd2147483647, 0, 0, 64'sd2147483647};
        send_segment(seg(p, 32'h00FF00FF, 32'hFF00FF00, 64'h80007FFF80007FFF,
                         64'h7FFF80007FFF8000));
    endtask

    task automatic random_segments();
        longint p[8];
        longint w;
        int kind;
        for (int n = 0; n < N_RANDOM; n++) begin
            kind = $urandom_range(0, 9);
            if (kind < 2) begin
                // raw full-range positions
                for (int i = 0; i < 8; i++) p[i] = longint'($signed($urandom));
            end else begin
                // near the view volume so partial clips dominate
                for (int v = 0; v < 2; v++) begin
                    w = longint'($urandom_range(ONE/8, 4*ONE));
                    if (kind == 9) w = -w;
                    for (int i = 0; i < 3; i++)
                        p[4*v+i] = longint'($urandom_range(0, 6*ONE)) - 3*ONE;
                    p[4*v+3] = w;
                end
                // sometimes pin a coordinate exactly onto a plane
                if (kind == 8) p[$urandom_range(0, 2)] = p[3];
            end
            send_segment(seg(p, $urandom, $urandom, rnd64(), rnd64()));
        end
    endtask

    initial begin
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        i_m_tready <= 1'b0;
        sent       = 0;
        burst_left = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed_segments();
        random_segments();
        i_s_tvalid <= 1'b0;

        // drain, then allow for anything the pipeline might still emit
        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);

        $display("covered %0d segments: %0d clipped vertex words, %0d rejects",
                 sent, vertices, rejects);
        $display("%0d mismatches in %0d cycles", errors, cycles);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
